[hdl/fet_pkg.sv]
// Shared types and constants for the free extent table.
package fet_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 32;
    localparam int LEN_W = 31;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_RECLAIM = 2'd1,
        CMD_ALLOC   = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_MISMATCH = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] size;
    } t_entry;

endpackage

[hdl/free_extent_table_top.sv]
// Free extent table: ordered first-fit list of free extents with a sequential scan.
//
//  Channel   Handshake          Payload
//  command   start / busy       i_cmd, i_position, i_length, i_exact_fit
//  result    o_valid (1 cycle)  o_status, o_alloc_position
//
// An add transaction completes from idle without raising busy. A reclaim or allocate visits
// S_READ and S_CHECK for each entry scanned, since the table memory read is registered,
// then S_SHIFT_RD and S_SHIFT_WR for each entry moved down when an entry is removed, and
// one more S_SHIFT_RD to close a removal.
// Reset clears the sequencer, the entry count and the result strobe; the table needs no
// clearing pass.
// The receiver cannot stall; each result shows for one cycle after the transaction ends.
module free_extent_table_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_cmd,
    input  logic [31:0]           i_position,
    input  logic [30:0]           i_length,
    input  logic                  i_exact_fit,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [31:0]           o_alloc_position
);
    import fet_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0] r_cmd, n_cmd;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_len, n_len;
    logic r_exact, n_exact;
    logic r_valid, n_valid;
    t_status r_status, n_status;
    logic [POS_W-1:0] r_apos, n_apos;

    logic rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry wr_data;

    logic [CNT_W-1:0] idx_next;
    logic fit;
    logic [LEN_W-1:0] new_size;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_idx    <= n_idx;
        r_cmd    <= n_cmd;
        r_pos    <= n_pos;
        r_len    <= n_len;
        r_exact  <= n_exact;
        r_status <= n_status;
        r_apos   <= n_apos;
    end

    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);
    assign new_size = r_rd_data.size - r_len;
    assign fit = r_exact ? (r_rd_data.size == r_len) : (r_rd_data.size >= r_len);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_cmd    = r_cmd;
        n_pos    = r_pos;
        n_len    = r_len;
        n_exact  = r_exact;
        n_valid  = 1'b0;
        n_status = r_status;
        n_apos   = r_apos;
        rd_en    = 1'b0;
        rd_addr  = r_idx;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_pos   = i_position;
                    n_len   = i_length;
                    n_exact = i_exact_fit;
                    n_idx   = '0;
                    n_apos  = '0;
                    if (i_cmd == CMD_ADD) begin
                        n_valid = 1'b1;
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            wr_en         = 1'b1;
                            wr_addr       = r_count[IDX_W-1:0];
                            wr_data.start = i_position;
                            wr_data.size  = i_length;
                            n_count       = r_count + CNT_W'(1);
                            n_status      = ST_OK;
                        end
                    end else if ((i_cmd == CMD_RECLAIM || i_cmd == CMD_ALLOC)
                                 && r_count != '0) begin
                        n_state = S_READ;
                    end else begin
                        n_valid  = 1'b1;
                        n_status = ST_NOTFOUND;
                    end
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_cmd == CMD_RECLAIM && r_rd_data.start == r_pos) begin
                    if (r_rd_data.size != r_len) begin
                        n_valid  = 1'b1;
                        n_status = ST_MISMATCH;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end else if (r_cmd == CMD_ALLOC && fit) begin
                    n_apos = r_rd_data.start;
                    if (new_size == '0) begin
                        n_state = S_SHIFT_RD;
                    end else begin
                        wr_en         = 1'b1;
                        wr_data.start = r_rd_data.start + POS_W'(r_len);
                        wr_data.size  = new_size;
                        n_valid       = 1'b1;
                        n_status      = ST_OK;
                        n_state       = S_IDLE;
                    end
                end else if (idx_next == r_count) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOTFOUND;
                    n_apos   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = idx_next[IDX_W-1:0];
                    n_state = S_READ;
                end
            end
            S_SHIFT_RD: begin
                if (idx_next < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_next[IDX_W-1:0];
                    n_state = S_SHIFT_WR;
                end else begin
                    n_count  = r_count - CNT_W'(1);
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end
            end
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                n_idx   = idx_next[IDX_W-1:0];
                n_state = S_SHIFT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_alloc_position = r_apos;

endmodule

[hdl/fet_checker.sv]
// Port-level checker for the free extent table, bound to the top level.
module fet_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_cmd,
    input logic [31:0] i_position,
    input logic [30:0] i_length,
    input logic        i_exact_fit,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [31:0] o_alloc_position
);
    import fet_pkg::*;

    // Every accepted transaction either keeps the block busy or yields a result at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("Accepted transaction produced neither busy nor a result.");

    // Leaving the busy phase always delivers the result in that cycle.
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("Busy dropped without a result strobe.");

    // A failed transaction reports a zero allocated position.
    a_fail_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_alloc_position == '0))
        else $error("Failed transaction reported a nonzero position.");

    // An add or an unused command is answered in the next cycle without going busy.
    a_add_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_ADD || i_cmd == CMD_UNUSED)) |=> (o_valid && !busy))
        else $error("Single-cycle transaction did not complete in one cycle.");

endmodule

bind free_extent_table_top fet_checker u_fet_checker (.*);

[tb/sv/free_extent_table_checker.sv]
// Checker for the free extent table: predicts each command's result and compares it.
module free_extent_table_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [1:0]                i_cmd,
    input  logic [fet_pkg::POS_W-1:0] i_position,
    input  logic [fet_pkg::LEN_W-1:0] i_length,
    input  logic                      i_exact_fit,
    input  logic                      i_valid,
    input  logic [1:0]                i_status,
    input  logic [fet_pkg::POS_W-1:0] i_alloc_position,
    output int                        o_errors,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fet_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] apos;
    } t_outcome;

    logic [POS_W-1:0] extent_start [DEPTH];
    logic [LEN_W-1:0] extent_size [DEPTH];
    int               extent_count = 0;
    t_outcome         outcome_q[$];

    function automatic void drop_extent(int idx);
        int k;
        for (k = idx; k + 1 < extent_count; k++) begin
            extent_start[k] = extent_start[k + 1];
            extent_size[k] = extent_size[k + 1];
        end
        extent_count--;
    endfunction

    function automatic t_outcome apply_command(logic [1:0] cmd, logic [POS_W-1:0] pos,
                                               logic [LEN_W-1:0] len, logic exact);
        t_outcome res;
        int       hit;
        int       i;
        res.status = ST_NOTFOUND;
        res.apos = '0;
        hit = -1;
        case (cmd)
            CMD_ADD: begin
                if (extent_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    extent_start[extent_count] = pos;
                    extent_size[extent_count] = len;
                    extent_count++;
                    res.status = ST_OK;
                end
            end
            CMD_RECLAIM: begin
                for (i = 0; i < extent_count; i++) begin
                    if (extent_start[i] == pos) begin
                        hit = i;
                        break;
                    end
                end
                if (hit >= 0) begin
                    if (extent_size[hit] != len) begin
                        res.status = ST_MISMATCH;
                    end else begin
                        drop_extent(hit);
                        res.status = ST_OK;
                    end
                end
            end
            CMD_ALLOC: begin
                for (i = 0; i < extent_count; i++) begin
                    if (exact ? (extent_size[i] == len) : (extent_size[i] >= len)) begin
                        hit = i;
                        break;
                    end
                end
                if (hit >= 0) begin
                    res.apos = extent_start[hit];
                    extent_start[hit] = extent_start[hit] + POS_W'(len);
                    extent_size[hit] = extent_size[hit] - len;
                    if (extent_size[hit] == '0) begin
                        drop_extent(hit);
                    end
                    res.status = ST_OK;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (!i_rst_n) begin
            extent_count = 0;
            outcome_q.delete();
        end else begin
            if (i_start && !i_busy) begin
                outcome_q.push_back(apply_command(i_cmd, i_position, i_length, i_exact_fit));
            end
            if (i_valid) begin
                if (outcome_q.size() == 0) begin
                    if (o_errors < 10) begin
                        $display("checker: result with no transaction pending: status %0d pos %h",
                                 i_status, i_alloc_position);
                    end
                    o_errors = o_errors + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.status !== i_status || want.apos !== i_alloc_position) begin
                        if (o_errors < 10) begin
                            $display("checker: mismatch: status exp %0d got %0d, pos exp %h got %h",
                                     want.status, i_status, want.apos, i_alloc_position);
                        end
                        o_errors = o_errors + 1;
                    end
                end
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

[tb/sv/testbench.sv]
// Testbench top for the free extent table: clock, reset, command stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fet_pkg::*;

    localparam int         CYCLE_LIMIT  = 1_500_000;
    localparam int         DRAIN_CYCLES = 4 * DEPTH + 32;
    localparam int         PHASE_ITEMS  = 350;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_cmd = CMD_ADD;
    logic [POS_W-1:0]  i_position = '0;
    logic [LEN_W-1:0]  i_length = '0;
    logic              i_exact_fit = 1'b0;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [POS_W-1:0]  o_alloc_position;
    int                error_count;
    int                pending_count;
    int                cycle_count = 0;
    int                idle_pct = 0;
    logic [POS_W-1:0]  known_pos[$];
    logic [LEN_W-1:0]  known_len[$];

    free_extent_table_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_length         (i_length),
        .i_exact_fit      (i_exact_fit),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_alloc_position (o_alloc_position)
    );

    free_extent_table_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_length         (i_length),
        .i_exact_fit      (i_exact_fit),
        .i_valid          (o_valid),
        .i_status         (o_status),
        .i_alloc_position (o_alloc_position),
        .o_errors         (error_count),
        .o_pending        (pending_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic issue(input logic [1:0] cmd, input logic [POS_W-1:0] pos,
                         input logic [LEN_W-1:0] len, input logic exact);
        int gap;
        i_cmd <= cmd;
        i_position <= pos;
        i_length <= len;
        i_exact_fit <= exact;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 12) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(9);
        if (r < 7) begin
            return 32'h0000_1000 + 32'($urandom_range(15)) * 32'd16;
        end else if (r < 8) begin
            return 32'hFFFF_FFF0 + 32'($urandom_range(15));
        end
        return $urandom();
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int          r;
        logic [31:0] raw;
        r = $urandom_range(9);
        raw = $urandom();
        if (r < 6) begin
            return LEN_W'($urandom_range(12));
        end else if (r < 8) begin
            return LEN_W'($urandom_range(4096));
        end else if (r < 9) begin
            return 31'h7FFF_FFFF - LEN_W'($urandom_range(3));
        end
        return raw[LEN_W-1:0];
    endfunction

    task automatic random_item(input int add_pct);
        int               r;
        int               k;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        r = $urandom_range(99);
        if (r < add_pct) begin
            pos = pick_position();
            len = pick_length();
            issue(CMD_ADD, pos, len, 1'($urandom_range(1)));
            known_pos.push_back(pos);
            known_len.push_back(len);
            if (known_pos.size() > DEPTH) begin
                void'(known_pos.pop_front());
                void'(known_len.pop_front());
            end
            return;
        end
        r = $urandom_range(99);
        k = (known_pos.size() > 0) ? $urandom_range(known_pos.size() - 1) : 0;
        if (r < 2) begin
            issue(CMD_UNUSED, $urandom(), pick_length(), 1'($urandom_range(1)));
        end else if (r < 30 && known_pos.size() > 0) begin
            issue(CMD_RECLAIM, known_pos[k], known_len[k], 1'($urandom_range(1)));
            known_pos.delete(k);
            known_len.delete(k);
        end else if (r < 40) begin
            issue(CMD_RECLAIM, pick_position(), pick_length(), 1'($urandom_range(1)));
        end else if (r < 70) begin
            issue(CMD_ALLOC, $urandom(), LEN_W'($urandom_range(8)), 1'b0);
        end else if (r < 85 && known_pos.size() > 0) begin
            issue(CMD_ALLOC, $urandom(), known_len[k], 1'b1);
        end else begin
            issue(CMD_ALLOC, $urandom(), pick_length(), 1'($urandom_range(1)));
        end
    endtask

    initial begin : stimulus
        int phase;
        int n;
        int burst_left;
        int add_pct;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(CMD_RECLAIM, 32'h0000_1000, 31'd4, 1'b0);
        issue(CMD_ALLOC, 32'h0, 31'd1, 1'b0);
        issue(CMD_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        issue(CMD_ADD, 32'hFFFF_FFFE, 31'd5, 1'b0);
        issue(CMD_ADD, 32'h0000_0000, 31'd0, 1'b1);
        issue(CMD_ADD, 32'h0000_1000, 31'h7FFF_FFFF, 1'b0);
        issue(CMD_ALLOC, 32'h0, 31'd3, 1'b0);
        issue(CMD_ALLOC, 32'h0, 31'd0, 1'b0);
        issue(CMD_ALLOC, 32'h0, 31'h7FFF_FFFF, 1'b1);
        issue(CMD_RECLAIM, 32'h0000_0001, 31'd7, 1'b0);
        issue(CMD_RECLAIM, 32'h0000_0001, 31'd2, 1'b1);
        issue(CMD_ALLOC, 32'h0, 31'd0, 1'b0);
        issue(CMD_ADD, 32'h0000_0020, 31'd4, 1'b0);
        issue(CMD_ADD, 32'h0000_0020, 31'd8, 1'b0);
        issue(CMD_RECLAIM, 32'h0000_0020, 31'd8, 1'b0);
        issue(CMD_ALLOC, 32'h0, 31'd9, 1'b1);
        issue(CMD_ALLOC, 32'h0, 31'd9, 1'b0);
        issue(CMD_ALLOC, 32'h0, 31'd4, 1'b1);
        issue(CMD_RECLAIM, 32'h0000_0020, 31'd0, 1'b0);

        burst_left = 0;
        add_pct = 50;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 61;
                2: idle_pct = 0;
                default: idle_pct = 17;
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    case ($urandom_range(2))
                        0: add_pct = 90;
                        1: add_pct = 55;
                        default: add_pct = 20;
                    endcase
                    burst_left = $urandom_range(20, 70);
                end
                burst_left--;
                random_item(add_pct);
            end
        end
        start <= 1'b0;

        do @(negedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
